### rtl/psa_pkg.sv
// shared constants, command codes and controller/datapath link types
package psa_pkg;

  localparam int SLOTS   = 8;
  localparam int SlotW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SlotInW = 3;
  localparam int IdW     = 8;
  localparam int TickW   = 16;
  localparam int BurstW  = 8;
  localparam int PrioW   = 8;

  typedef enum logic {
    CmdLoad = 1'b0,
    CmdTick = 1'b1
  } command_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_we;
    logic scan_clr;
    logic scan_step;
    logic scan_last;
    logic exec;
  } psa_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic running;
    logic scan_at_end;
  } psa_status_t;

endpackage

### rtl/psa_ctrl.sv
// controller state machine: sequences load, selection scan and tick execution
module psa_ctrl import psa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        command_i,
  input  psa_status_t status_i,
  output psa_cmd_t    cmd_o,
  output logic        busy
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StExec
  } state_e;

  state_e state_d, state_q;
  logic   accept;

  assign accept = start && (state_q == StIdle);
  assign busy   = (state_q != StIdle);

  always_comb begin
    cmd_o.load_we   = accept && (command_i == CmdLoad);
    cmd_o.scan_clr  = accept && (command_i == CmdTick) && !status_i.running;
    cmd_o.scan_step = (state_q == StScan);
    cmd_o.scan_last = (state_q == StScan) && status_i.scan_at_end;
    cmd_o.exec      = (state_q == StExec);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (command_i == CmdTick)) begin
          state_d = status_i.running ? StExec : StScan;
        end
      end
      StScan: begin
        if (status_i.scan_at_end) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  a_exec_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec) |=> (state_q == StIdle))
    else $error("exec not followed by idle");

  a_scan_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> !status_i.running)
    else $error("selection scan while a job is running");

endmodule

### rtl/psa_dp.sv
// datapath: job entries, selection scan, aging, work count and result register
module psa_dp import psa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psa_cmd_t             cmd_i,
  output psa_status_t          status_o,
  input  logic [SlotInW-1:0]   slot_i,
  input  logic [IdW-1:0]       job_id_i,
  input  logic [TickW-1:0]     arrival_tick_i,
  input  logic [BurstW-1:0]    burst_length_i,
  input  logic [PrioW-1:0]     start_priority_i,
  output logic                 result_valid_o,
  output logic                 idle_o,
  output logic [IdW-1:0]       running_id_o,
  output logic                 finished_o,
  output logic [IdW-1:0]       finished_id_o,
  output logic [TickW-1:0]     turnaround_o,
  output logic [TickW-1:0]     waiting_o
);

  localparam int SlotExtW = SlotInW + SlotW;

  // entry storage
  logic [SLOTS-1:0]  valid_q, done_q;
  logic [IdW-1:0]    id_q    [SLOTS];
  logic [TickW-1:0]  arr_q   [SLOTS];
  logic [BurstW-1:0] burst_q [SLOTS];
  logic [BurstW-1:0] work_q  [SLOTS];
  logic [PrioW-1:0]  prio_q  [SLOTS];

  // scheduler state
  logic [TickW-1:0]  tick_q;
  logic              running_q;
  logic [SlotW-1:0]  cur_q;

  // scan state
  logic [SlotW-1:0]  scan_q;
  logic              found_q;
  logic [SlotW-1:0]  best_slot_q;
  logic [PrioW-1:0]  best_prio_q;
  logic [TickW-1:0]  best_arr_q;

  // result register
  logic              res_valid_q, idle_q, fin_q;
  logic [IdW-1:0]    run_id_q, fin_id_q;
  logic [TickW-1:0]  ta_q, wt_q;

  logic [SlotExtW-1:0] slot_ext;
  logic [SlotW-1:0]    ld_idx;
  logic                ld_ok;
  logic [SLOTS-1:0]    elig;
  logic [SlotW-1:0]    rd_idx;
  logic [PrioW-1:0]    prio_rd;
  logic [TickW-1:0]    arr_rd;
  logic [BurstW-1:0]   burst_rd, work_rd, work_inc;
  logic [IdW-1:0]      id_rd;
  logic                take, fin;
  logic [TickW-1:0]    ta, wt;

  assign slot_ext = SlotExtW'(slot_i);
  assign ld_idx   = slot_ext[SlotW-1:0];
  assign ld_ok    = slot_ext < SlotExtW'(SLOTS);

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      elig[s] = valid_q[s] && !done_q[s] && (arr_q[s] <= tick_q);
    end
  end

  // one read index: scan position during selection, running slot during exec
  assign rd_idx   = cmd_i.exec ? cur_q : scan_q;
  assign prio_rd  = prio_q[rd_idx];
  assign arr_rd   = arr_q[rd_idx];
  assign burst_rd = burst_q[rd_idx];
  assign work_rd  = work_q[rd_idx];
  assign id_rd    = id_q[rd_idx];

  // ties go to the later arrival, then the higher slot (scan runs upward)
  assign take = elig[rd_idx] && (!found_q || (prio_rd > best_prio_q) ||
                ((prio_rd == best_prio_q) && (arr_rd >= best_arr_q)));

  assign work_inc = (work_rd == '1) ? work_rd : work_rd + BurstW'(1);
  assign fin      = (work_inc >= burst_rd);
  assign ta       = tick_q + TickW'(1) - arr_rd;
  assign wt       = ta - TickW'(burst_rd);

  assign status_o.running     = running_q;
  assign status_o.scan_at_end = (scan_q == SlotW'(SLOTS - 1));

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      done_q      <= '0;
      tick_q      <= '0;
      running_q   <= 1'b0;
      cur_q       <= '0;
      scan_q      <= '0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.exec;
      if (cmd_i.load_we && ld_ok) begin
        valid_q[ld_idx] <= 1'b1;
        done_q[ld_idx]  <= 1'b0;
        if (running_q && (cur_q == ld_idx)) begin
          running_q <= 1'b0;
        end
      end
      if (cmd_i.scan_clr) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        scan_q <= scan_q + SlotW'(1);
        if (take) begin
          found_q <= 1'b1;
        end
        if (cmd_i.scan_last) begin
          running_q <= found_q || take;
          if (take) begin
            cur_q <= scan_q;
          end else if (found_q) begin
            cur_q <= best_slot_q;
          end
        end
      end
      if (cmd_i.exec) begin
        tick_q <= tick_q + TickW'(1);
        if (running_q && fin) begin
          done_q[cur_q] <= 1'b1;
          running_q     <= 1'b0;
        end
      end
    end
  end

  // payload: entry fields, scan best and result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && ld_ok) begin
      id_q[ld_idx]    <= job_id_i;
      arr_q[ld_idx]   <= arrival_tick_i;
      burst_q[ld_idx] <= burst_length_i;
      work_q[ld_idx]  <= '0;
      prio_q[ld_idx]  <= start_priority_i;
    end
    if (cmd_i.scan_step && take) begin
      best_slot_q <= scan_q;
      best_prio_q <= prio_rd;
      best_arr_q  <= arr_rd;
    end
    if (cmd_i.exec) begin
      if (running_q) begin
        work_q[cur_q] <= work_inc;
        for (int s = 0; s < SLOTS; s++) begin
          if ((SlotW'(s) != cur_q) && elig[s] && (prio_q[s] != '1)) begin
            prio_q[s] <= prio_q[s] + PrioW'(1);
          end
        end
      end
      idle_q   <= !running_q;
      run_id_q <= running_q ? id_rd : '0;
      fin_q    <= running_q && fin;
      fin_id_q <= (running_q && fin) ? id_rd : '0;
      ta_q     <= (running_q && fin) ? ta : '0;
      wt_q     <= (running_q && fin) ? wt : '0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign idle_o         = idle_q;
  assign running_id_o   = run_id_q;
  assign finished_o     = fin_q;
  assign finished_id_o  = fin_id_q;
  assign turnaround_o   = ta_q;
  assign waiting_o      = wt_q;

  a_running_entry_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (valid_q[cur_q] && !done_q[cur_q]))
    else $error("running slot is not a live entry");

  a_finish_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && fin_q) |-> !running_q)
    else $error("job reported finished but still running");

  a_idle_not_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && idle_q) |-> !fin_q)
    else $error("idle tick reported a finished job");

endmodule

### rtl/priority_scheduler_with_aging.sv
// top level of the non-preemptive priority scheduler with aging
//
//  channel   handshake                      payload
//  -------   ----------------------------   --------------------------------------
//  command   start (in), busy (out)         command_i slot_i job_id_i arrival_tick_i
//                                           burst_length_i start_priority_i
//  result    result_valid_o (1-cycle)       idle_o running_id_o finished_o
//                                           finished_id_o turnaround_o waiting_o
//
// a beat is taken at a rising edge with start high and busy low
// load beat: entry written at the accepting edge, busy stays low, no result
// tick beat with a job running: straight to exec, result strobe on the cycle after exec
// tick beat with no job running: a scan of all SLOTS entries (one entry per cycle in the
//   selection compare), then exec, result strobe on the cycle after exec
// reset clears tick count, running flag and entry valid/done bits at once;
//   results are never held off, the strobe lasts exactly one cycle
module priority_scheduler_with_aging import psa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 start,
  output logic                 busy,
  input  logic                 command_i,
  input  logic [SlotInW-1:0]   slot_i,
  input  logic [IdW-1:0]       job_id_i,
  input  logic [TickW-1:0]     arrival_tick_i,
  input  logic [BurstW-1:0]    burst_length_i,
  input  logic [PrioW-1:0]     start_priority_i,
  // result channel
  output logic                 result_valid_o,
  output logic                 idle_o,
  output logic [IdW-1:0]       running_id_o,
  output logic                 finished_o,
  output logic [IdW-1:0]       finished_id_o,
  output logic [TickW-1:0]     turnaround_o,
  output logic [TickW-1:0]     waiting_o
);

  // controller to datapath command bundle and status back
  psa_cmd_t    cmd;
  psa_status_t status;

  // sequencer: idle -> scan (only when nothing runs) -> exec -> idle
  psa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy      (busy)
  );

  // entry table, selection scan, aging and the registered result beat
  psa_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .slot_i           (slot_i),
    .job_id_i         (job_id_i),
    .arrival_tick_i   (arrival_tick_i),
    .burst_length_i   (burst_length_i),
    .start_priority_i (start_priority_i),
    .result_valid_o   (result_valid_o),
    .idle_o           (idle_o),
    .running_id_o     (running_id_o),
    .finished_o       (finished_o),
    .finished_id_o    (finished_id_o),
    .turnaround_o     (turnaround_o),
    .waiting_o        (waiting_o)
  );

endmodule

### verif/priority_scheduler_with_aging_tb.sv
// self-checking testbench for the priority scheduler with aging
module priority_scheduler_with_aging_tb;
  import psa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one command beat as it goes onto the ports
  typedef struct packed {
    command_e              cmd;
    logic [SlotInW-1:0]    slot;
    logic [IdW-1:0]        job_id;
    logic [TickW-1:0]      arrival;
    logic [BurstW-1:0]     burst;
    logic [PrioW-1:0]      prio;
  } sched_beat_t;

  // what one tick beat reports on the result ports
  typedef struct packed {
    logic                  idle;
    logic [IdW-1:0]        running_id;
    logic                  finished;
    logic [IdW-1:0]        finished_id;
    logic [TickW-1:0]      turnaround;
    logic [TickW-1:0]      waiting;
  } tick_outcome_t;

  // shadow copy of the job table plus the queue of tick outcomes still owed
  class sched_scoreboard;
    bit [TickW-1:0]  tick_now;
    bit              job_running;
    bit [SlotW-1:0]  run_slot;
    bit              slot_loaded [SLOTS];
    bit              slot_done   [SLOTS];
    bit [IdW-1:0]    slot_id     [SLOTS];
    bit [TickW-1:0]  slot_arrival[SLOTS];
    bit [BurstW-1:0] slot_burst  [SLOTS];
    bit [BurstW-1:0] slot_work   [SLOTS];
    bit [PrioW-1:0]  slot_prio   [SLOTS];
    tick_outcome_t   expected_ticks[$];
    int unsigned     errors;

    function new();
      errors = 0;
    endfunction

    // loaded, not finished and already arrived
    function bit is_ready(int s);
      return slot_loaded[s] && !slot_done[s] && (slot_arrival[s] <= tick_now);
    endfunction

    // one scheduling tick: select if free, age the waiters, work the runner
    function tick_outcome_t run_one_tick();
      tick_outcome_t o;
      bit            found;
      int            best;
      o     = '0;
      found = 1'b0;
      best  = 0;
      if (!job_running) begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!is_ready(s)) continue;
          // ties on priority go to the later arrival, then the higher slot
          if (!found || slot_prio[s] > slot_prio[best] ||
              (slot_prio[s] == slot_prio[best] && slot_arrival[s] >= slot_arrival[best])) begin
            best  = s;
            found = 1'b1;
          end
        end
        if (found) begin
          run_slot    = best[SlotW-1:0];
          job_running = 1'b1;
        end
      end
      if (!job_running) begin
        // empty tick, nothing waits so nothing ages
        o.idle   = 1'b1;
        tick_now = tick_now + TickW'(1);
        return o;
      end
      for (int s = 0; s < SLOTS; s++) begin
        if (s != run_slot && is_ready(s) && slot_prio[s] != '1)
          slot_prio[s] = slot_prio[s] + PrioW'(1);
      end
      o.running_id = slot_id[run_slot];
      if (slot_work[run_slot] != '1)
        slot_work[run_slot] = slot_work[run_slot] + BurstW'(1);
      if (slot_work[run_slot] >= slot_burst[run_slot]) begin
        o.finished    = 1'b1;
        o.finished_id = slot_id[run_slot];
        o.turnaround  = tick_now + TickW'(1) - slot_arrival[run_slot];
        o.waiting     = o.turnaround - TickW'(slot_burst[run_slot]);
        slot_done[run_slot] = 1'b1;
        job_running         = 1'b0;
      end
      tick_now = tick_now + TickW'(1);
      return o;
    endfunction

    // called once per accepted beat
    function void note_beat(sched_beat_t b);
      int s;
      if (b.cmd == CmdLoad) begin
        s = int'(b.slot);
        if (s >= SLOTS) return;
        slot_loaded[s]  = 1'b1;
        slot_done[s]    = 1'b0;
        slot_id[s]      = b.job_id;
        slot_arrival[s] = b.arrival;
        slot_burst[s]   = b.burst;
        slot_work[s]    = '0;
        slot_prio[s]    = b.prio;
        // overwriting the running entry drops it, next tick selects anew
        if (job_running && run_slot == s) job_running = 1'b0;
      end else begin
        expected_ticks.push_back(run_one_tick());
      end
    endfunction

    function void compare_field(string name, logic [TickW-1:0] want, logic [TickW-1:0] got,
                                ref bit bad);
      if (got !== want) begin
        bad = 1'b1;
        $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // called once per result strobe
    function void check_outcome(tick_outcome_t got);
      tick_outcome_t want;
      bit            bad;
      bad = 1'b0;
      if (expected_ticks.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: expected none, actual %0h", $time, got);
        return;
      end
      want = expected_ticks.pop_front();
      compare_field("idle",        TickW'(want.idle),        TickW'(got.idle),        bad);
      compare_field("running_id",  TickW'(want.running_id),  TickW'(got.running_id),  bad);
      compare_field("finished",    TickW'(want.finished),    TickW'(got.finished),    bad);
      compare_field("finished_id", TickW'(want.finished_id), TickW'(got.finished_id), bad);
      compare_field("turnaround",  want.turnaround,          got.turnaround,          bad);
      compare_field("waiting",     want.waiting,             got.waiting,             bad);
      if (bad) errors++;
    endfunction

    function int unsigned owed();
      return expected_ticks.size();
    endfunction

    function bit clean();
      if (expected_ticks.size() != 0)
        $display("%0t %0d tick results never arrived: expected %0d more, actual 0",
                 $time, expected_ticks.size(), expected_ticks.size());
      return (errors == 0) && (expected_ticks.size() == 0);
    endfunction
  endclass

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 start            = 1'b0;
  logic                 busy;
  logic                 command_i        = 1'b0;
  logic [SlotInW-1:0]   slot_i           = '0;
  logic [IdW-1:0]       job_id_i         = '0;
  logic [TickW-1:0]     arrival_tick_i   = '0;
  logic [BurstW-1:0]    burst_length_i   = '0;
  logic [PrioW-1:0]     start_priority_i = '0;
  logic                 result_valid_o;
  logic                 idle_o;
  logic [IdW-1:0]       running_id_o;
  logic                 finished_o;
  logic [IdW-1:0]       finished_id_o;
  logic [TickW-1:0]     turnaround_o;
  logic [TickW-1:0]     waiting_o;

  sched_scoreboard sb;
  bit              steady_run;   // no sender gaps while set

  priority_scheduler_with_aging DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .slot_i           (slot_i),
    .job_id_i         (job_id_i),
    .arrival_tick_i   (arrival_tick_i),
    .burst_length_i   (burst_length_i),
    .start_priority_i (start_priority_i),
    .result_valid_o   (result_valid_o),
    .idle_o           (idle_o),
    .running_id_o     (running_id_o),
    .finished_o       (finished_o),
    .finished_id_o    (finished_id_o),
    .turnaround_o     (turnaround_o),
    .waiting_o        (waiting_o)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // results cannot be held off, so every strobe is checked at the edge closing it
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid_o === 1'b1)
      sb.check_outcome(tick_outcome_t'{idle_o, running_id_o, finished_o, finished_id_o,
                                       turnaround_o, waiting_o});
  end

  function automatic sched_beat_t load_beat(logic [SlotInW-1:0] s, logic [IdW-1:0] id,
                                            logic [TickW-1:0] arr, logic [BurstW-1:0] bl,
                                            logic [PrioW-1:0] pr);
    sched_beat_t b;
    b.cmd     = CmdLoad;
    b.slot    = s;
    b.job_id  = id;
    b.arrival = arr;
    b.burst   = bl;
    b.prio    = pr;
    return b;
  endfunction

  // payload of a tick beat is ignored, so fill it with noise
  function automatic sched_beat_t tick_beat();
    sched_beat_t b;
    b      = sched_beat_t'({$urandom, $urandom});
    b.cmd  = CmdTick;
    return b;
  endfunction

  // mostly ticks; loads arrive around the current tick so jobs actually get scheduled
  function automatic sched_beat_t random_beat();
    int unsigned      r;
    logic [TickW-1:0] arr;
    logic [BurstW-1:0] bl;
    logic [PrioW-1:0] pr;
    r = $urandom_range(99, 0);
    if (r < 65) return tick_beat();
    if (r < 70)  // noise: anything goes
      return load_beat(SlotInW'($urandom_range(7, 0)), IdW'($urandom_range(255, 0)),
                       TickW'($urandom_range(65535, 0)), BurstW'($urandom_range(255, 1)),
                       PrioW'($urandom_range(255, 0)));
    r = $urandom_range(99, 0);
    if (r < 60)      arr = sb.tick_now - TickW'($urandom_range(10, 0));
    else if (r < 90) arr = sb.tick_now + TickW'($urandom_range(20, 0));
    else             arr = TickW'($urandom_range(65535, 0));
    r = $urandom_range(99, 0);
    if (r < 80)      bl = BurstW'($urandom_range(6, 1));
    else if (r < 95) bl = BurstW'($urandom_range(40, 7));
    else             bl = BurstW'($urandom_range(255, 41));
    // narrow priorities make ties common
    pr = ($urandom_range(9, 0) < 7) ? PrioW'($urandom_range(7, 0))
                                    : PrioW'($urandom_range(255, 0));
    return load_beat(SlotInW'($urandom_range(7, 0)), IdW'($urandom_range(255, 0)),
                     arr, bl, pr);
  endfunction

  // put a beat on the ports at this edge and hold it until it is taken
  task automatic issue_beat(sched_beat_t b);
    command_i        <= b.cmd;
    slot_i           <= b.slot;
    job_id_i         <= b.job_id;
    arrival_tick_i   <= b.arrival;
    burst_length_i   <= b.burst;
    start_priority_i <= b.prio;
    start            <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_beat(b);
  endtask

  // mostly short gaps, a few long ones, none at all during steady runs
  task automatic pause_sender();
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(99, 0);
    if (steady_run || r < 45) gap = 0;
    else if (r < 90)          gap = $urandom_range(3, 1);
    else                      gap = $urandom_range(40, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned guard;
    int unsigned haul_ticks;
    sb = new();
    steady_run = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty tick, field extremes, tie breaks, zero burst, reload of the runner
    issue_beat(tick_beat());
    issue_beat(load_beat(3'd0, 8'h00, 16'h0000, 8'd1,   8'h00));
    issue_beat(load_beat(3'd7, 8'hFF, 16'hFFFF, 8'd255, 8'hFF));   // not eligible for ages
    issue_beat(load_beat(3'd3, 8'h5A, 16'h0000, 8'd2,   8'h09));
    issue_beat(load_beat(3'd5, 8'hA5, 16'h0000, 8'd2,   8'h09));   // same prio and arrival
    issue_beat(load_beat(3'd2, 8'h3C, 16'h0001, 8'd0,   8'h09));   // later arrival, zero burst
    pause_sender();
    issue_beat(tick_beat());
    issue_beat(tick_beat());
    issue_beat(load_beat(3'd5, 8'hC3, 16'h0000, 8'd4,   8'h00));   // lands on the running slot
    issue_beat(tick_beat());
    pause_sender();
    issue_beat(tick_beat());
    issue_beat(load_beat(3'd1, 8'h81, 16'h0004, 8'd3,   8'hFE));
    for (int i = 0; i < 6; i++) begin
      issue_beat(tick_beat());
      pause_sender();
    end
    issue_beat(load_beat(3'd4, 8'h7E, 16'h8000, 8'd1,   8'h80));
    for (int i = 0; i < 5; i++) issue_beat(tick_beat());

    // random traffic, with steady stretches switched in and out
    for (int n = 0; n < 1100; n++) begin
      if (n % 150 == 0) steady_run = ($urandom_range(2, 0) == 0);
      issue_beat(random_beat());
      pause_sender();
    end

    // long jobs with high priorities keep the block running,
    // which drives waiting priorities into saturation
    steady_run = 1'b1;
    haul_ticks = 240;
    for (int unsigned i = 0; i < haul_ticks; i++) begin
      if (i % 48 == 0)
        issue_beat(load_beat(SlotInW'($urandom_range(7, 0)), IdW'($urandom_range(255, 0)),
                             sb.tick_now + TickW'($urandom_range(30, 0)), 8'd255,
                             PrioW'($urandom_range(255, 200))));
      issue_beat(tick_beat());
    end

    // some ordinary traffic to finish
    steady_run = 1'b0;
    for (int n = 0; n < 120; n++) begin
      issue_beat(random_beat());
      pause_sender();
    end
    start <= 1'b0;

    // drain, then give the block time for any stray strobe
    guard = 0;
    while (sb.owed() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (16) @(posedge clk_i);
    if (sb.clean())
      $display("priority_scheduler_with_aging verification clean");
    else
      $display("priority_scheduler_with_aging verification failed");
    $finish;
  end

  // hang guard
  initial begin
    #50ms;
    $display("priority_scheduler_with_aging verification failed");
    $finish;
  end

endmodule

### filelist.f
rtl/psa_pkg.sv
rtl/psa_ctrl.sv
rtl/psa_dp.sv
rtl/priority_scheduler_with_aging.sv
verif/priority_scheduler_with_aging_tb.sv
